// ===== design/svpwm_ss_pkg.sv =====
// svpwm segment sequencer package: field widths, reset values, command struct
// and the vector to gate decode shared by the interfaces, controller and datapath
// no dependencies
package svpwm_ss_pkg;

	localparam int SEGMENTS_DEF    = 7;
	localparam int COUNT_WIDTH_DEF = 16;

	localparam int DUR_W    = 16;
	localparam int VEC_W    = 4;
	localparam int SLOT_W   = 3;
	localparam int PERIOD_W = 16;
	localparam int GATE_W   = 6;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(100);
	localparam logic [VEC_W-1:0]    BLANK_VEC    = VEC_W'(8);

	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_LOAD = 1'b1;

	typedef struct packed {
		logic tick;
		logic load;
	} cmd_t;

	// upper switch on for the named legs, lower is the complement
	function automatic logic [GATE_W-1:0] decode_gates(input logic [VEC_W-1:0] v);
		logic [GATE_W-1:0] g;
		case (v)
			4'd0:    g = 6'h2A;
			4'd1:    g = 6'h29;
			4'd2:    g = 6'h25;
			4'd3:    g = 6'h26;
			4'd4:    g = 6'h16;
			4'd5:    g = 6'h1A;
			4'd6:    g = 6'h19;
			4'd7:    g = 6'h15;
			default: g = 6'h00;
		endcase
		return g;
	endfunction

endpackage

// ===== design/svpwm_ss_if.sv =====
// svpwm segment sequencer channel interfaces: item, result and config write
// depends on svpwm_ss_pkg
interface svpwm_ss_item_if;
	logic                              valid;
	logic                              ready;
	logic                              func;
	logic                              channel;
	logic [svpwm_ss_pkg::SLOT_W-1:0]   segment_slot;
	logic [svpwm_ss_pkg::DUR_W-1:0]    segment_duration;
	logic [svpwm_ss_pkg::VEC_W-1:0]    segment_vector;

	modport source (output valid, func, channel, segment_slot, segment_duration,
		segment_vector, input ready);
	modport sink (input valid, func, channel, segment_slot, segment_duration,
		segment_vector, output ready);
endinterface

interface svpwm_ss_result_if;
	logic                              valid;
	logic                              ready;
	logic [svpwm_ss_pkg::GATE_W-1:0]   gates_first;
	logic [svpwm_ss_pkg::GATE_W-1:0]   gates_second;
	logic                              control_tick;

	modport source (output valid, gates_first, gates_second, control_tick, input ready);
	modport sink (input valid, gates_first, gates_second, control_tick, output ready);
endinterface

interface svpwm_ss_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [svpwm_ss_pkg::PERIOD_W-1:0]   control_period;

	modport source (output valid, control_period, input ready);
	modport sink (input valid, control_period, output ready);
endinterface

// ===== design/svpwm_ss_ctrl.sv =====
// svpwm segment sequencer controller: item handshake and result register state
// depends on svpwm_ss_pkg
module svpwm_ss_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               item_func,
	output logic               item_ready,
	input  logic               result_ready,
	output logic               result_valid,
	output svpwm_ss_pkg::cmd_t cmd
);
	import svpwm_ss_pkg::*;

	typedef enum logic {
		OUT_EMPTY,
		OUT_FULL
	} state_t;

	state_t state_q;
	logic   accept;

	assign item_ready = (state_q == OUT_EMPTY) || result_ready;
	assign accept     = item_valid && item_ready;
	assign cmd.tick   = accept && (item_func == FUNC_TICK);
	assign cmd.load   = accept && (item_func == FUNC_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= OUT_EMPTY;
			result_valid <= 1'b0;
		end else begin
			case (state_q)
				OUT_EMPTY: begin
					if (cmd.tick) begin
						state_q      <= OUT_FULL;
						result_valid <= 1'b1;
					end
				end
				OUT_FULL: begin
					if (result_ready && !cmd.tick) begin
						state_q      <= OUT_EMPTY;
						result_valid <= 1'b0;
					end
				end
				default: begin
					state_q      <= OUT_EMPTY;
					result_valid <= 1'b0;
				end
			endcase
		end
	end

endmodule

// ===== design/svpwm_ss_dpath.sv =====
// svpwm segment sequencer datapath: segment tables, period and segment counters,
// next segment search and gate decode into the result register; depends on svpwm_ss_pkg
module svpwm_ss_dpath #(
	parameter int SEGMENTS    = svpwm_ss_pkg::SEGMENTS_DEF,
	parameter int COUNT_WIDTH = svpwm_ss_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  svpwm_ss_pkg::cmd_t                  cmd,
	input  logic                                channel,
	input  logic [svpwm_ss_pkg::SLOT_W-1:0]     segment_slot,
	input  logic [svpwm_ss_pkg::DUR_W-1:0]      segment_duration,
	input  logic [svpwm_ss_pkg::VEC_W-1:0]      segment_vector,
	input  logic                                cfg_write,
	input  logic [svpwm_ss_pkg::PERIOD_W-1:0]   cfg_period,
	output logic [svpwm_ss_pkg::GATE_W-1:0]     gates_first,
	output logic [svpwm_ss_pkg::GATE_W-1:0]     gates_second,
	output logic                                control_tick
);
	import svpwm_ss_pkg::*;

	localparam int POS_W = $clog2(SEGMENTS);
	localparam int CMP_W = (COUNT_WIDTH > DUR_W) ? COUNT_WIDTH : DUR_W;

	logic [DUR_W-1:0]       dur_tbl_q [2][SEGMENTS];
	logic [VEC_W-1:0]       vec_tbl_q [2][SEGMENTS];
	logic [PERIOD_W-1:0]    period_cfg_q;
	logic [PERIOD_W-1:0]    period_cnt_q;
	logic [COUNT_WIDTH-1:0] seg_cnt_q [2];
	logic [POS_W-1:0]       seg_pos_q [2];

	logic                   ctl_tick;
	logic [PERIOD_W-1:0]    period_d;
	logic [POS_W-1:0]       base_pos [2];
	logic [POS_W-1:0]       next_pos [2];
	logic [POS_W-1:0]       new_pos [2];
	logic [COUNT_WIDTH-1:0] base_cnt [2];
	logic [COUNT_WIDTH-1:0] new_cnt [2];
	logic [DUR_W-1:0]       cur_dur [2];
	logic [VEC_W-1:0]       new_vec [2];
	logic                   slot_ok;
	logic [POS_W-1:0]       wr_pos;

	assign ctl_tick = period_cnt_q >= period_cfg_q;
	assign period_d = ctl_tick ? '0 : period_cnt_q + 1'b1;
	assign slot_ok  = int'(segment_slot) < SEGMENTS;
	assign wr_pos   = POS_W'(segment_slot);

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			base_pos[c] = ctl_tick ? '0 : seg_pos_q[c];
			base_cnt[c] = ctl_tick ? '0 : seg_cnt_q[c];
			cur_dur[c]  = dur_tbl_q[c][base_pos[c]];
			// first nonzero segment after the current one, else the last
			next_pos[c] = POS_W'(SEGMENTS - 1);
			for (int j = SEGMENTS - 1; j > 0; j--) begin
				if (j > int'(base_pos[c]) && dur_tbl_q[c][j] != '0) begin
					next_pos[c] = POS_W'(j);
				end
			end
			if (CMP_W'(base_cnt[c]) >= CMP_W'(cur_dur[c])) begin
				new_cnt[c] = '0;
				new_pos[c] = next_pos[c];
			end else begin
				new_cnt[c] = (base_cnt[c] == '1) ? base_cnt[c] : base_cnt[c] + 1'b1;
				new_pos[c] = base_pos[c];
			end
			new_vec[c] = vec_tbl_q[c][new_pos[c]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_cfg_q <= PERIOD_RESET;
			period_cnt_q <= '0;
			for (int c = 0; c < 2; c++) begin
				seg_cnt_q[c] <= '0;
				seg_pos_q[c] <= '0;
				for (int s = 0; s < SEGMENTS; s++) begin
					dur_tbl_q[c][s] <= '0;
					vec_tbl_q[c][s] <= BLANK_VEC;
				end
			end
		end else begin
			if (cfg_write) begin
				period_cfg_q <= cfg_period;
			end
			if (cmd.load && slot_ok) begin
				dur_tbl_q[channel][wr_pos] <= segment_duration;
				vec_tbl_q[channel][wr_pos] <= segment_vector;
			end
			if (cmd.tick) begin
				period_cnt_q <= period_d;
				for (int c = 0; c < 2; c++) begin
					seg_cnt_q[c] <= new_cnt[c];
					seg_pos_q[c] <= new_pos[c];
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.tick) begin
			gates_first  <= decode_gates(new_vec[0]);
			gates_second <= decode_gates(new_vec[1]);
			control_tick <= ctl_tick;
		end
	end

endmodule

// ===== design/svpwm_segment_sequencer_unit.sv =====
// svpwm segment sequencer top level: controller plus datapath behind the channels
// depends on svpwm_ss_pkg, svpwm_ss_if, svpwm_ss_ctrl, svpwm_ss_dpath
//
//  channel  dir  payload                                                    transfer
//  item     in   func, channel, segment_slot, segment_duration, segment_vector  valid & ready
//  result   out  gates_first, gates_second, control_tick                    valid & ready
//  cfg      in   control_period                                             valid & ready
//
// one item per cycle when not stalled: a tick is resolved in the cycle it is taken and
// lands in the result register; a load writes the segment tables and returns nothing
// the result register is the only buffer, so item ready drops while a result is stalled
// cfg is always ready; control_period resets to 100, tables to zero duration and blank
// reset is asynchronous and leaves no result pending, no clearing pass
module svpwm_segment_sequencer_unit #(
	parameter int SEGMENTS    = svpwm_ss_pkg::SEGMENTS_DEF,
	parameter int COUNT_WIDTH = svpwm_ss_pkg::COUNT_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	svpwm_ss_item_if.sink             item,
	svpwm_ss_result_if.source         result,
	svpwm_ss_cfg_if.sink              cfg
);
	import svpwm_ss_pkg::*;

	cmd_t cmd;

	assign cfg.ready = 1'b1;

	svpwm_ss_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_func    (item.func),
		.item_ready   (item.ready),
		.result_ready (result.ready),
		.result_valid (result.valid),
		.cmd          (cmd)
	);

	svpwm_ss_dpath #(
		.SEGMENTS    (SEGMENTS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.channel          (item.channel),
		.segment_slot     (item.segment_slot),
		.segment_duration (item.segment_duration),
		.segment_vector   (item.segment_vector),
		.cfg_write        (cfg.valid),
		.cfg_period       (cfg.control_period),
		.gates_first      (result.gates_first),
		.gates_second     (result.gates_second),
		.control_tick     (result.control_tick)
	);

	a_tick_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && item.func == FUNC_TICK) |=> result.valid)
		else $error("tick transfer did not produce a result");

	a_load_gives_none: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && item.func == FUNC_LOAD && !result.valid)
		|=> !result.valid)
		else $error("load transfer produced a result");

	a_stall_blocks_item: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |-> !item.ready)
		else $error("item taken while result stalled");

endmodule

// ===== test/tb_top.sv =====
// testbench for svpwm_segment_sequencer_unit: loads and ticks with random gaps and stalls,
// every tick's gates and control tick checked against a predictor in gate_scoreboard
// depends on svpwm_ss_pkg, svpwm_ss_if and the design files
`timescale 1ns / 100ps

module tb_top;
	import svpwm_ss_pkg::*;

	localparam int SEGS   = SEGMENTS_DEF;
	localparam int CNT_W  = COUNT_WIDTH_DEF;
	localparam int LIMIT  = 200000;
	localparam int SETTLE = 8;
	localparam int PHASE_ITEMS = 90;

	typedef struct packed {
		logic              func;
		logic              chan;
		logic [SLOT_W-1:0] slot;
		logic [DUR_W-1:0]  dur;
		logic [VEC_W-1:0]  vec;
	} seg_item_t;

	typedef struct packed {
		logic [GATE_W-1:0] gfirst;
		logic [GATE_W-1:0] gsecond;
		logic              ctl_tick;
	} gate_set_t;

	class gate_scoreboard;
		logic [PERIOD_W-1:0] period_reg;
		logic [PERIOD_W-1:0] period_cnt;
		logic [CNT_W-1:0]    seg_cnt [2];
		int unsigned         seg_pos [2];
		logic [VEC_W-1:0]    active_vec [2];
		logic [DUR_W-1:0]    dur_tab [2][SEGS];
		logic [VEC_W-1:0]    vec_tab [2][SEGS];
		gate_set_t           expected_q [$];
		int                  errors;
		int                  ticks;
		int                  loads;
		int                  ctl_seen;

		function new();
			period_reg = PERIOD_RESET;
			period_cnt = '0;
			for (int ch = 0; ch < 2; ch++) begin
				seg_cnt[ch] = '0;
				seg_pos[ch] = 0;
				active_vec[ch] = BLANK_VEC;
				for (int s = 0; s < SEGS; s++) begin
					dur_tab[ch][s] = '0;
					vec_tab[ch][s] = BLANK_VEC;
				end
			end
			errors = 0;
			ticks = 0;
			loads = 0;
			ctl_seen = 0;
		endfunction

		function void set_period(logic [PERIOD_W-1:0] v);
			period_reg = v;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// upper switch per leg, lower is its complement
		function logic [GATE_W-1:0] gate_pattern(logic [VEC_W-1:0] v);
			logic [2:0]        upper;
			logic [GATE_W-1:0] g;
			if (v >= BLANK_VEC)
				return '0;
			case (v)
				4'd1:    upper = 3'b001;
				4'd2:    upper = 3'b011;
				4'd3:    upper = 3'b010;
				4'd4:    upper = 3'b110;
				4'd5:    upper = 3'b100;
				4'd6:    upper = 3'b101;
				4'd7:    upper = 3'b111;
				default: upper = 3'b000;
			endcase
			for (int k = 0; k < 3; k++) begin
				g[2*k]   = upper[k];
				g[2*k+1] = ~upper[k];
			end
			return g;
		endfunction

		function void advance(int ch);
			int unsigned p;
			bit          done;
			p = seg_pos[ch];
			if (p >= SEGS)
				p = SEGS - 1;
			if (seg_cnt[ch] >= dur_tab[ch][p]) begin
				seg_cnt[ch] = '0;
				done = 0;
				// skip zero-length segments, hold at the last one
				while (!done) begin
					if (p + 1 >= SEGS) begin
						p = SEGS - 1;
						done = 1;
					end else begin
						p++;
						done = (dur_tab[ch][p] != '0);
					end
				end
			end else if (seg_cnt[ch] != '1) begin
				seg_cnt[ch] = seg_cnt[ch] + 1'b1;
			end
			seg_pos[ch] = p;
			active_vec[ch] = vec_tab[ch][p];
		endfunction

		function void note_item(seg_item_t it);
			gate_set_t e;
			if (it.func == FUNC_LOAD) begin
				loads++;
				if (it.slot < SEGS) begin
					dur_tab[it.chan][it.slot] = it.dur;
					vec_tab[it.chan][it.slot] = it.vec;
				end
				return;
			end
			ticks++;
			e.ctl_tick = 1'b0;
			if (period_cnt >= period_reg) begin
				period_cnt = '0;
				e.ctl_tick = 1'b1;
				for (int ch = 0; ch < 2; ch++) begin
					seg_cnt[ch] = '0;
					seg_pos[ch] = 0;
				end
			end else begin
				period_cnt = period_cnt + 1'b1;
			end
			advance(0);
			advance(1);
			e.gfirst = gate_pattern(active_vec[0]);
			e.gsecond = gate_pattern(active_vec[1]);
			expected_q.push_back(e);
		endfunction

		function void check_result(gate_set_t got);
			gate_set_t e;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result gates_first %h gates_second %h control_tick %b",
					$time, got.gfirst, got.gsecond, got.ctl_tick);
				return;
			end
			e = expected_q.pop_front();
			if (got.ctl_tick === 1'b1)
				ctl_seen++;
			if (got.gfirst !== e.gfirst) begin
				errors++;
				$display("%0t: gates_first expected %h actual %h", $time, e.gfirst, got.gfirst);
			end
			if (got.gsecond !== e.gsecond) begin
				errors++;
				$display("%0t: gates_second expected %h actual %h", $time, e.gsecond, got.gsecond);
			end
			if (got.ctl_tick !== e.ctl_tick) begin
				errors++;
				$display("%0t: control_tick expected %b actual %b", $time, e.ctl_tick, got.ctl_tick);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int   cycles = 0;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   cfg_writes = 0;

	gate_scoreboard sb = new();

	svpwm_ss_item_if   item_bus ();
	svpwm_ss_result_if result_bus ();
	svpwm_ss_cfg_if    cfg_bus ();

	svpwm_segment_sequencer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus),
		.cfg    (cfg_bus)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, sb.pending());
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(negedge clk) begin
		result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
			sb.check_result('{result_bus.gates_first, result_bus.gates_second,
				result_bus.control_tick});
	end

	function automatic seg_item_t mk(logic f, logic ch, int slot, int dur, int vec);
		seg_item_t it;
		it.func = f;
		it.chan = ch;
		it.slot = SLOT_W'(slot);
		it.dur = DUR_W'(dur);
		it.vec = VEC_W'(vec);
		return it;
	endfunction

	function automatic logic [DUR_W-1:0] rand_duration();
		int r;
		r = $urandom_range(99);
		if (r < 20)
			return '0;
		if (r < 85)
			return DUR_W'($urandom_range(6, 1));
		if (r < 93)
			return DUR_W'($urandom_range(40, 7));
		if (r < 96)
			return '1;
		return DUR_W'($urandom());
	endfunction

	function automatic seg_item_t rand_item();
		seg_item_t it;
		it.func = ($urandom_range(99) < 30) ? FUNC_LOAD : FUNC_TICK;
		it.chan = 1'($urandom_range(1));
		it.slot = SLOT_W'($urandom_range(7));
		it.dur = rand_duration();
		it.vec = ($urandom_range(99) < 80) ? VEC_W'($urandom_range(8))
			: VEC_W'($urandom_range(15, 9));
		return it;
	endfunction

	task automatic send_item(seg_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			item_bus.valid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		item_bus.valid <= 1'b1;
		item_bus.func <= it.func;
		item_bus.channel <= it.chan;
		item_bus.segment_slot <= it.slot;
		item_bus.segment_duration <= it.dur;
		item_bus.segment_vector <= it.vec;
		do @(posedge clk); while (item_bus.ready !== 1'b1);
		sb.note_item(it);
	endtask

	// stop sending, wait for all results and let the block settle
	task automatic quiesce();
		@(negedge clk);
		item_bus.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_period(logic [PERIOD_W-1:0] v);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.control_period <= v;
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		sb.set_period(v);
		cfg_writes++;
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	initial begin
		logic [PERIOD_W-1:0] per;
		arst_n = 1'b0;
		item_bus.valid = 1'b0;
		item_bus.func = FUNC_TICK;
		item_bus.channel = 1'b0;
		item_bus.segment_slot = '0;
		item_bus.segment_duration = '0;
		item_bus.segment_vector = '0;
		result_bus.ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.control_period = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty tables, skips, end of table, unused codes, ignored slot
		send_item(mk(FUNC_TICK, 0, 0, 0, 0));
		send_item(mk(FUNC_LOAD, 0, 0, 2, 0));
		send_item(mk(FUNC_LOAD, 0, 1, 0, 7));
		send_item(mk(FUNC_LOAD, 0, 2, 65535, 7));
		send_item(mk(FUNC_LOAD, 0, 3, 1, 2));
		send_item(mk(FUNC_LOAD, 0, 6, 1, 15));
		send_item(mk(FUNC_LOAD, 0, 7, 3, 1));
		send_item(mk(FUNC_LOAD, 1, 0, 1, 1));
		send_item(mk(FUNC_LOAD, 1, 1, 1, 2));
		send_item(mk(FUNC_LOAD, 1, 2, 0, 3));
		send_item(mk(FUNC_LOAD, 1, 3, 1, 4));
		send_item(mk(FUNC_LOAD, 1, 4, 1, 5));
		send_item(mk(FUNC_LOAD, 1, 5, 1, 6));
		send_item(mk(FUNC_LOAD, 1, 6, 0, BLANK_VEC));
		send_item(mk(FUNC_TICK, 0, 0, 0, 0));
		send_item(mk(FUNC_TICK, 1, 7, 65535, 15));
		quiesce();
		write_period('0);
		repeat (3) send_item(mk(FUNC_TICK, 0, 0, 0, 0));
		quiesce();
		write_period(PERIOD_W'(4));
		repeat (6) send_item(mk(FUNC_TICK, 0, 0, 0, 0));

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0:       per = PERIOD_RESET;
				1:       per = '1;
				2:       per = '0;
				5:       per = PERIOD_W'(7);
				6:       per = PERIOD_W'($urandom_range(300, 41));
				default: per = PERIOD_W'($urandom_range(40, 3));
			endcase
			quiesce();
			write_period(per);
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 61;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 61;
				end
				default: begin
					send_idle_pct = 22;
					recv_stall_pct = 22;
				end
			endcase
			repeat (PHASE_ITEMS) send_item(rand_item());
		end
		quiesce();

		$display("run covered %0d ticks and %0d loads, %0d control ticks, %0d period writes",
			sb.ticks, sb.loads, sb.ctl_seen, cfg_writes);
		$display("periods from 0 to 65535, with sender gaps and receiver stalls, %0d errors",
			sb.errors);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
